// ----- rtl/insertion_sorter_macros.svh -----
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

`ifndef SYNTH

// property checked at every clock edge outside reset
`define ISORT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold at every clock edge, reset included
`define ISORT_ASSERT_ALWAYS(lbl, clk, cond, msg) \
	lbl: assert property (@(posedge clk) cond) else $error(msg);

`else

`define ISORT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISORT_ASSERT_ALWAYS(lbl, clk, cond, msg)

`endif

`endif

// ----- rtl/isort_pkg.sv -----
// shared types and constants of the insertion sorter
`timescale 1ns / 1ps

package isort_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;

	// data handed between neighboring cells
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic                     valid;
		logic                     gt;
	} isort_link_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic shift;
	} isort_ctl_t;

endpackage

// ----- rtl/isort_cell.sv -----
// one compare-and-shift cell of the sorting chain
`timescale 1ns / 1ps

module isort_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  isort_pkg::isort_ctl_t                ctl,
	input  logic signed [isort_pkg::DATA_W-1:0]  ins_value,
	input  isort_pkg::isort_link_t               lower,
	input  isort_pkg::isort_link_t               upper,
	output isort_pkg::isort_link_t               self
);

	logic signed [isort_pkg::DATA_W-1:0] data_q;
	logic                                valid_q;
	logic                                gt;
	logic                                load_ins;
	logic signed [isort_pkg::DATA_W-1:0] ins_data;

	// strict compare keeps equal values in arrival order
	assign gt       = valid_q && (data_q > ins_value);
	assign load_ins = ctl.ins && (gt || (!valid_q && lower.valid));
	assign ins_data = lower.gt ? lower.data : ins_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= upper.valid;
		end else if (load_ins) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= upper.data;
		end else if (load_ins) begin
			data_q <= ins_data;
		end
	end

	assign self.data  = data_q;
	assign self.valid = valid_q;
	assign self.gt    = gt;

endmodule

// ----- rtl/insertion_sorter.sv -----
// insertion sorter top level: chain of cells plus emission control
// a request is inserted at its accept edge; after a last request the
// sorted set leaves one result per cycle, starting the next cycle
// throughput: one request per cycle while a set loads, set by one compare per cell;
// busy stays high while the set is emitted after a last request
// results cannot be stalled: res_strobe marks each one for a single cycle
// reset (arst_n low) empties every cell and clears the emission and overflow state
`timescale 1ns / 1ps
`include "insertion_sorter_macros.svh"

module insertion_sorter #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                                last,
	output logic                                res_strobe,
	output logic signed [isort_pkg::DATA_W-1:0] value_res,
	output logic                                last_res,
	output logic                                overflow
);

	// links between cells, index 0 holds the smallest value
	isort_pkg::isort_link_t link [DEPTH];
	isort_pkg::isort_link_t bottom_link;
	isort_pkg::isort_link_t top_link;
	isort_pkg::isort_ctl_t  ctl;

	logic             emit_q;      // set is being drained out of cell 0
	logic             dropped_q;   // a value of this set was dropped
	logic             accept;
	logic             full;
	logic             final_res;
	logic [DEPTH-1:0] valid_vec;

	// request handshake: take one value whenever no set is draining
	assign accept = start && !emit_q;
	assign full   = link[DEPTH-1].valid;

	// insert only with room left, otherwise the value is dropped
	assign ctl.ins   = accept && !full;
	// during emission every cell takes its upper neighbor's value
	assign ctl.shift = emit_q;

	// below cell 0 sits a permanently valid, never-greater slot
	assign bottom_link.data  = '0;
	assign bottom_link.valid = 1'b1;
	assign bottom_link.gt    = 1'b0;
	// above the top cell nothing is held, so draining empties the chain
	assign top_link.data  = '0;
	assign top_link.valid = 1'b0;
	assign top_link.gt    = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		isort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.ins_value (value),
			.lower     ((i == 0) ? bottom_link : link[(i == 0) ? 0 : i-1]),
			.upper     ((i == DEPTH-1) ? top_link : link[(i == DEPTH-1) ? i : i+1]),
			.self      (link[i])
		);
		assign valid_vec[i] = link[i].valid;
	end

	// the result in cell 0 is the final one once cell 1 is empty
	assign final_res = emit_q && !link[1].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else if (emit_q) begin
			if (final_res) begin
				emit_q    <= 1'b0;
				dropped_q <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				dropped_q <= 1'b1;
			end
			if (last) begin
				emit_q <= 1'b1;
			end
		end
	end

	// result ports come straight from cell 0 and the control registers
	assign busy       = emit_q;
	assign res_strobe = emit_q;
	assign value_res  = link[0].data;
	assign last_res   = final_res;
	assign overflow   = emit_q && dropped_q;

	// occupied cells always form a contiguous run from cell 0
	`ISORT_ASSERT_ALWAYS(a_valid_run, clk, ((valid_vec + 1'b1) & valid_vec) == '0, "cell chain has a gap")
	// every emitted result comes from an occupied cell
	`ISORT_ASSERT(a_res_valid, clk, arst_n, res_strobe |-> link[0].valid, "result from empty cell")
	// the final result ends emission and leaves the chain empty
	`ISORT_ASSERT(a_set_done, clk, arst_n, last_res |=> (!busy && !link[0].valid && !dropped_q), "set not closed")
	// a request on a full chain marks the set as overflowed
	`ISORT_ASSERT(a_drop_flag, clk, arst_n, (start && !busy && full) |=> dropped_q, "drop not flagged")

endmodule
